/* sv/assert_macros.svh */
// Assertion macros for the translation lookup RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, held off while in reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/nwtl_pkg.sv */
// ----------------------------------------------------------------------------
// nwtl_pkg
// Types and codes shared by the wildcard translation lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package nwtl_pkg;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_TRANSLATE = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_PORT  = 2'd2;
    localparam logic [1:0] KIND_MISS  = 2'd3;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] ip_addr;
        logic [15:0] port;
        logic        ip_any;
        logic        port_any;
        logic [31:0] new_ip;
        logic [15:0] new_port;
    } in_t;

    typedef struct packed {
        logic [1:0]  match_kind;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic [1:0]  insert_status;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        TBL_EXACT,
        TBL_ADDR,
        TBL_PORT
    } tbl_t;

endpackage
`default_nettype wire

/* sv/nat_wildcard_translation_lookup.sv */
// ----------------------------------------------------------------------------
// nat_wildcard_translation_lookup
// Three rule tables (exact, address-only, port-only) searched entry by entry.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | nwtl_pkg::in_t
// out     | out | out_valid / out_ready| nwtl_pkg::out_t
//
// Rules only leave a table through a clear, so the filled entries of a table
// are always 0 .. count-1 and a fill count per table stands for the valid bits.
// Each filled entry probed passes a memory read state (S_RD) and a compare
// state (S_CMP); reaching the end of a table's filled entries takes one more
// read state, and the result is registered into the output register from S_FIN.
// Clear, unused code and both-wildcard inserts go straight to S_FIN. Reset and
// clear zero the fill counts. A new transfer is taken while the previous
// result still waits in the output register; an out_ready held low then stalls
// the engine in its final state.
`default_nettype none
`include "assert_macros.svh"
module nat_wildcard_translation_lookup #(
    parameter int EXACT_DEPTH = 256,
    parameter int ADDR_DEPTH  = 256,
    parameter int PORT_DEPTH  = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire nwtl_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output nwtl_pkg::out_t       out_data
);

    localparam int EW  = (EXACT_DEPTH > 1) ? $clog2(EXACT_DEPTH) : 1;
    localparam int AW  = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
    localparam int PW  = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1;
    localparam int ECW = $clog2(EXACT_DEPTH + 1);
    localparam int ACW = $clog2(ADDR_DEPTH + 1);
    localparam int PCW = $clog2(PORT_DEPTH + 1);
    localparam int IW  = (ECW > ACW) ? ((ECW > PCW) ? ECW : PCW) : ((ACW > PCW) ? ACW : PCW);

    // Memories: {key, target}
    logic [95:0] e_mem [EXACT_DEPTH];
    logic [79:0] a_mem [ADDR_DEPTH];
    logic [63:0] p_mem [PORT_DEPTH];
    logic [95:0] e_rd_reg;
    logic [79:0] a_rd_reg;
    logic [63:0] p_rd_reg;

    // Fill counts
    logic [ECW-1:0] e_cnt_reg;
    logic [ACW-1:0] a_cnt_reg;
    logic [PCW-1:0] p_cnt_reg;

    nwtl_pkg::state_t state_reg, state_next;
    nwtl_pkg::tbl_t   tbl_reg, tbl_next;
    nwtl_pkg::in_t    item_reg, item_next;
    nwtl_pkg::out_t   res_reg, res_next;
    nwtl_pkg::out_t   out_reg;
    logic             out_valid_reg;
    logic [IW-1:0]    idx_reg, idx_next;

    logic          accept, load_out, is_ins, cur_valid, full, hit, do_write;
    logic [IW-1:0] cur_cnt, cur_depth;
    logic [47:0]   hit_target;

    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == nwtl_pkg::S_FIN) && (!out_valid_reg || out_ready);
    assign is_ins   = (item_reg.operation == nwtl_pkg::OP_INSERT);

    // Per-table view of the current entry
    always_comb
    begin
        case (tbl_reg)
            nwtl_pkg::TBL_EXACT:
            begin
                cur_cnt    = IW'(e_cnt_reg);
                cur_depth  = IW'(EXACT_DEPTH);
                hit        = (e_rd_reg[95:48] == {item_reg.ip_addr, item_reg.port});
                hit_target = e_rd_reg[47:0];
            end
            nwtl_pkg::TBL_ADDR:
            begin
                cur_cnt    = IW'(a_cnt_reg);
                cur_depth  = IW'(ADDR_DEPTH);
                hit        = (a_rd_reg[79:48] == item_reg.ip_addr);
                hit_target = a_rd_reg[47:0];
            end
            default:
            begin
                cur_cnt    = IW'(p_cnt_reg);
                cur_depth  = IW'(PORT_DEPTH);
                hit        = (p_rd_reg[63:48] == item_reg.port);
                hit_target = p_rd_reg[47:0];
            end
        endcase
    end

    assign cur_valid = (idx_reg < cur_cnt);
    assign full      = (cur_cnt == cur_depth);
    // End of an insert scan with no duplicate and room left
    assign do_write  = (state_reg == nwtl_pkg::S_RD) && is_ins && !cur_valid && !full;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nwtl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_data.operation == nwtl_pkg::OP_INSERT &&
                         !(in_data.ip_any && in_data.port_any)) ||
                        in_data.operation == nwtl_pkg::OP_TRANSLATE)
                        state_next = nwtl_pkg::S_RD;
                    else
                        state_next = nwtl_pkg::S_FIN;
                end
            end
            nwtl_pkg::S_RD:
            begin
                if (cur_valid)
                    state_next = nwtl_pkg::S_CMP;
                else if (is_ins || tbl_reg == nwtl_pkg::TBL_PORT)
                    state_next = nwtl_pkg::S_FIN;
            end
            nwtl_pkg::S_CMP:
            begin
                if (hit)
                    state_next = nwtl_pkg::S_FIN;
                else
                    state_next = nwtl_pkg::S_RD;
            end
            nwtl_pkg::S_FIN:
            begin
                if (load_out)
                    state_next = nwtl_pkg::S_IDLE;
            end
            default: state_next = nwtl_pkg::S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        tbl_next  = tbl_reg;
        item_next = item_reg;
        res_next  = res_reg;
        idx_next  = idx_reg;
        case (state_reg)
            nwtl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    idx_next  = '0;
                    res_next  = '{match_kind: nwtl_pkg::KIND_MISS, out_ip: '0,
                                  out_port: '0, insert_status: nwtl_pkg::ST_STORED};
                    if (in_data.operation == nwtl_pkg::OP_INSERT && in_data.ip_any &&
                        in_data.port_any)
                        res_next.insert_status = nwtl_pkg::ST_IGNORED;
                    if (in_data.operation == nwtl_pkg::OP_INSERT && in_data.ip_any)
                        tbl_next = nwtl_pkg::TBL_PORT;
                    else if (in_data.operation == nwtl_pkg::OP_INSERT && in_data.port_any)
                        tbl_next = nwtl_pkg::TBL_ADDR;
                    else
                        tbl_next = nwtl_pkg::TBL_EXACT;
                end
            end
            nwtl_pkg::S_RD:
            begin
                // End of the filled entries: store, report full or next table
                if (!cur_valid)
                begin
                    if (is_ins)
                    begin
                        if (full)
                            res_next.insert_status = nwtl_pkg::ST_FULL;
                    end
                    else if (tbl_reg != nwtl_pkg::TBL_PORT)
                    begin
                        idx_next = '0;
                        tbl_next = (tbl_reg == nwtl_pkg::TBL_EXACT) ? nwtl_pkg::TBL_ADDR
                                                                    : nwtl_pkg::TBL_PORT;
                    end
                end
            end
            nwtl_pkg::S_CMP:
            begin
                if (hit)
                begin
                    if (is_ins)
                        res_next.insert_status = nwtl_pkg::ST_DUP;
                    else
                    begin
                        res_next.out_ip   = hit_target[47:16];
                        res_next.out_port = hit_target[15:0];
                        case (tbl_reg)
                            nwtl_pkg::TBL_EXACT: res_next.match_kind = nwtl_pkg::KIND_EXACT;
                            nwtl_pkg::TBL_ADDR:  res_next.match_kind = nwtl_pkg::KIND_ADDR;
                            default:             res_next.match_kind = nwtl_pkg::KIND_PORT;
                        endcase
                    end
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nwtl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            e_cnt_reg     <= '0;
            a_cnt_reg     <= '0;
            p_cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (accept && in_data.operation == nwtl_pkg::OP_CLEAR)
            begin
                e_cnt_reg <= '0;
                a_cnt_reg <= '0;
                p_cnt_reg <= '0;
            end
            else if (do_write)
            begin
                case (tbl_reg)
                    nwtl_pkg::TBL_EXACT: e_cnt_reg <= e_cnt_reg + ECW'(1);
                    nwtl_pkg::TBL_ADDR:  a_cnt_reg <= a_cnt_reg + ACW'(1);
                    default:             p_cnt_reg <= p_cnt_reg + PCW'(1);
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tbl_reg  <= tbl_next;
        item_reg <= item_next;
        res_reg  <= res_next;
        idx_reg  <= idx_next;
        if (load_out)
            out_reg <= res_reg;
    end

    // Rule memories: one read and one write port each
    always_ff @(posedge clk)
    begin
        if (state_reg == nwtl_pkg::S_RD && cur_valid)
        begin
            case (tbl_reg)
                nwtl_pkg::TBL_EXACT: e_rd_reg <= e_mem[idx_reg[EW-1:0]];
                nwtl_pkg::TBL_ADDR:  a_rd_reg <= a_mem[idx_reg[AW-1:0]];
                default:             p_rd_reg <= p_mem[idx_reg[PW-1:0]];
            endcase
        end
        if (do_write && tbl_reg == nwtl_pkg::TBL_EXACT)
            e_mem[idx_reg[EW-1:0]] <= {item_reg.ip_addr, item_reg.port,
                                        item_reg.new_ip, item_reg.new_port};
        if (do_write && tbl_reg == nwtl_pkg::TBL_ADDR)
            a_mem[idx_reg[AW-1:0]] <= {item_reg.ip_addr,
                                        item_reg.new_ip, item_reg.new_port};
        if (do_write && tbl_reg == nwtl_pkg::TBL_PORT)
            p_mem[idx_reg[PW-1:0]] <= {item_reg.port,
                                        item_reg.new_ip, item_reg.new_port};
    end

    assign in_ready  = (state_reg == nwtl_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `ASSERT_CLK(a_accept_leaves_idle, accept |=> state_reg != nwtl_pkg::S_IDLE, "accept stayed idle")
    `ASSERT_CLK(a_load_sets_valid, load_out |=> out_valid_reg, "result not presented")
    `ASSERT_CLK(a_write_at_fill, do_write |-> idx_reg == cur_cnt, "write away from fill point")
    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result lost")

endmodule
`default_nettype wire

/* tb/sv/nat_wildcard_translation_lookup_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nat_wildcard_translation_lookup_tb
// Self-checking bench for the wildcard translation lookup. A queue-fed
// driver and a clocked monitor surround the block; a local rule-table model
// predicts one result per accepted transfer and results are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none
module nat_wildcard_translation_lookup_tb;

    localparam int DEPTH      = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 3000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    nwtl_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    nwtl_pkg::out_t out_data;

    nat_wildcard_translation_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Pending transfers and the results they should give
    nwtl_pkg::in_t  item_q[$];
    nwtl_pkg::out_t pending_results[$];

    // Local copy of the three rule tables
    logic [47:0] exact_key [DEPTH];
    logic [47:0] exact_tgt [DEPTH];
    logic        exact_vld [DEPTH];
    logic [31:0] addr_key  [DEPTH];
    logic [47:0] addr_tgt  [DEPTH];
    logic        addr_vld  [DEPTH];
    logic [15:0] prt_key   [DEPTH];
    logic [47:0] prt_tgt   [DEPTH];
    logic        prt_vld   [DEPTH];

    int   idle_mode;
    int   errors = 0;
    int   stall_cycles;
    logic in_took;
    logic hold_req;
    logic hold_done;
    int   hold_cnt;

    logic [31:0] ip_pool [16];
    logic [15:0] port_pool [16];

    // Rule insert into one of the tables, first free slot wins
    function automatic logic [1:0] store_exact(logic [47:0] k, logic [47:0] t);
        int slot;
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (exact_vld[i] && exact_key[i] == k)
                return nwtl_pkg::ST_DUP;
            if (!exact_vld[i] && slot < 0)
                slot = i;
        end
        if (slot < 0)
            return nwtl_pkg::ST_FULL;
        exact_key[slot] = k;
        exact_tgt[slot] = t;
        exact_vld[slot] = 1'b1;
        return nwtl_pkg::ST_STORED;
    endfunction

    function automatic logic [1:0] store_addr(logic [31:0] k, logic [47:0] t);
        int slot;
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (addr_vld[i] && addr_key[i] == k)
                return nwtl_pkg::ST_DUP;
            if (!addr_vld[i] && slot < 0)
                slot = i;
        end
        if (slot < 0)
            return nwtl_pkg::ST_FULL;
        addr_key[slot] = k;
        addr_tgt[slot] = t;
        addr_vld[slot] = 1'b1;
        return nwtl_pkg::ST_STORED;
    endfunction

    function automatic logic [1:0] store_port(logic [15:0] k, logic [47:0] t);
        int slot;
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (prt_vld[i] && prt_key[i] == k)
                return nwtl_pkg::ST_DUP;
            if (!prt_vld[i] && slot < 0)
                slot = i;
        end
        if (slot < 0)
            return nwtl_pkg::ST_FULL;
        prt_key[slot] = k;
        prt_tgt[slot] = t;
        prt_vld[slot] = 1'b1;
        return nwtl_pkg::ST_STORED;
    endfunction

    // Expected result of one transfer; updates the local tables
    function automatic nwtl_pkg::out_t translate_item(nwtl_pkg::in_t it);
        nwtl_pkg::out_t r;
        logic [47:0]    tgt;
        logic           hit;
        r   = '{match_kind: nwtl_pkg::KIND_MISS, out_ip: '0, out_port: '0,
                insert_status: nwtl_pkg::ST_STORED};
        tgt = {it.new_ip, it.new_port};
        hit = 1'b0;
        case (it.operation)
            nwtl_pkg::OP_INSERT:
            begin
                if (it.ip_any && it.port_any)
                    r.insert_status = nwtl_pkg::ST_IGNORED;
                else if (it.ip_any)
                    r.insert_status = store_port(it.port, tgt);
                else if (it.port_any)
                    r.insert_status = store_addr(it.ip_addr, tgt);
                else
                    r.insert_status = store_exact({it.ip_addr, it.port}, tgt);
            end
            nwtl_pkg::OP_TRANSLATE:
            begin
                for (int i = 0; i < DEPTH && !hit; i++)
                    if (exact_vld[i] && exact_key[i] == {it.ip_addr, it.port})
                    begin
                        hit = 1'b1;
                        r.match_kind = nwtl_pkg::KIND_EXACT;
                        {r.out_ip, r.out_port} = exact_tgt[i];
                    end
                for (int i = 0; i < DEPTH && !hit; i++)
                    if (addr_vld[i] && addr_key[i] == it.ip_addr)
                    begin
                        hit = 1'b1;
                        r.match_kind = nwtl_pkg::KIND_ADDR;
                        {r.out_ip, r.out_port} = addr_tgt[i];
                    end
                for (int i = 0; i < DEPTH && !hit; i++)
                    if (prt_vld[i] && prt_key[i] == it.port)
                    begin
                        hit = 1'b1;
                        r.match_kind = nwtl_pkg::KIND_PORT;
                        {r.out_ip, r.out_port} = prt_tgt[i];
                    end
            end
            nwtl_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    exact_vld[i] = 1'b0;
                    addr_vld[i]  = 1'b0;
                    prt_vld[i]   = 1'b0;
                end
            end
            default:
            begin
                // unused code: tables untouched
            end
        endcase
        return r;
    endfunction

    function automatic nwtl_pkg::in_t make_item(logic [1:0] op, logic [31:0] ip,
                                                logic [15:0] pt, logic ia, logic pa);
        nwtl_pkg::in_t it;
        it.operation = op;
        it.ip_addr   = ip;
        it.port      = pt;
        it.ip_any    = ia;
        it.port_any  = pa;
        it.new_ip    = $urandom;
        it.new_port  = 16'($urandom);
        return it;
    endfunction

    // Random key content, mostly from small pools so rules get hit
    function automatic nwtl_pkg::in_t random_item();
        int          sel;
        logic [1:0]  op;
        logic [31:0] ip;
        logic [15:0] pt;
        sel = $urandom_range(0, 99);
        if (sel < 42)
            op = nwtl_pkg::OP_INSERT;
        else if (sel < 95)
            op = nwtl_pkg::OP_TRANSLATE;
        else if (sel < 98)
            op = nwtl_pkg::OP_CLEAR;
        else
            op = nwtl_pkg::OP_UNUSED;
        ip = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 15)];
        pt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 15)];
        return make_item(op, ip, pt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Fill one table past capacity, then probe it
    task automatic fill_table(int which);
        nwtl_pkg::in_t it;
        item_q.push_back(make_item(nwtl_pkg::OP_CLEAR, $urandom, 16'($urandom), 1'b0, 1'b0));
        for (int i = 0; i < DEPTH + 4; i++)
        begin
            it = make_item(nwtl_pkg::OP_INSERT, $urandom, 16'($urandom), which == 2,
                           which == 1);
            if (which != 2)
                it.ip_addr = {16'(i), 16'(i * 7)};
            if (which != 1)
                it.port = 16'(i * 3);
            item_q.push_back(it);
        end
        it = make_item(nwtl_pkg::OP_INSERT, {16'd5, 16'd35}, 16'd15, which == 2, which == 1);
        item_q.push_back(it);
        it = make_item(nwtl_pkg::OP_TRANSLATE, {16'd255, 16'd1785}, 16'd765, 1'b0, 1'b0);
        item_q.push_back(it);
        it = make_item(nwtl_pkg::OP_TRANSLATE, {16'd258, 16'd1806}, 16'd774, 1'b0, 1'b0);
        item_q.push_back(it);
    endtask

    task automatic drain();
        while (item_q.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: presents the next pending item after the previous transfer
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_took)
        begin
            if (item_q.size() != 0 &&
                $urandom_range(0, 99) >= (idle_mode == 0 ? 13 : idle_mode == 1 ? 68 : 0))
            begin
                in_data  <= item_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= $urandom_range(0, 99) >=
                         (idle_mode == 0 ? 68 : idle_mode == 1 ? 13 : 0);
    end

    // Monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        nwtl_pkg::out_t want;
        if (!rst_n)
        begin
            in_took      <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
                pending_results.push_back(translate_item(in_data));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want !== out_data)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: kind %0d/%0d ip %h/%h port %h/%h st %0d/%0d",
                                     want.match_kind, out_data.match_kind,
                                     want.out_ip, out_data.out_ip,
                                     want.out_port, out_data.out_port,
                                     want.insert_status, out_data.insert_status);
                    end
                end
            end
            // watchdog on cycles with no transfer at all
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin
        rst_n     = 1'b0;
        idle_mode = 0;
        hold_req  = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            exact_vld[i] = 1'b0;
            addr_vld[i]  = 1'b0;
            prt_vld[i]   = 1'b0;
        end
        for (int i = 0; i < 16; i++)
        begin
            ip_pool[i]   = $urandom;
            port_pool[i] = 16'($urandom);
        end
        ip_pool[0]   = '0;
        ip_pool[1]   = '1;
        port_pool[0] = '0;
        port_pool[1] = '1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each operation, priority order, duplicates, corner codes
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '1, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_INSERT, '1, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_INSERT, '1, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '1, '1, 1'b1, 1'b1));
        item_q.push_back(make_item(nwtl_pkg::OP_INSERT, '1, 16'd0, 1'b0, 1'b1));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '1, 16'd7, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '1, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_INSERT, '0, '1, 1'b1, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, 32'h1234_5678, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_INSERT, '0, '0, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '0, '0, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_INSERT, 32'h0a00_0001, 16'd80, 1'b1, 1'b1));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, 32'h0a00_0001, 16'd80, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_UNUSED, '1, '1, 1'b1, 1'b1));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '1, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_CLEAR, '1, '1, 1'b1, 1'b1));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '1, '1, 1'b0, 1'b0));
        item_q.push_back(make_item(nwtl_pkg::OP_TRANSLATE, '0, '0, 1'b0, 1'b0));
        drain();

        // Random phases, sender pauses until all results are back between them
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_mode = ph;
            fill_table(ph);
            for (int i = 0; i < 250; i++)
                item_q.push_back(random_item());
            if (ph == 2)
            begin
                for (int i = 0; i < 40; i++)
                    item_q.push_back(random_item());
                hold_req = 1'b1;
            end
            drain();
        end

        repeat (2000) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/nwtl_pkg.sv
sv/nat_wildcard_translation_lookup.sv
tb/sv/nat_wildcard_translation_lookup_tb.sv
